[sv/rsdk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdk_pkg
// shared types and constants of the descending-key record sorter
// ----------------------------------------------------------------------------

package rsdk_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int ID_W        = 32;
    localparam int HANDLE_W    = 16;
    localparam int SCORE_W     = 11;
    localparam int REC_W       = ID_W + HANDLE_W + SCORE_W;
    localparam int TDATA_W     = ((REC_W + 7) / 8) * 8;

    // packed so that the id sits in the lowest bits
    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
    } t_rec;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // insert the incoming record
        logic pop;   // shift the chain toward the head
    } t_cell_ctrl;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

endpackage

[sv/rsdk_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdk_cell
// one slot of the sorted chain: keeps, takes the new record, or shifts
// ----------------------------------------------------------------------------

module rsdk_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsdk_pkg::t_cell_ctrl i_ctrl,
    input  rsdk_pkg::t_rec      i_new,
    input  rsdk_pkg::t_rec      i_prev_rec,
    input  logic                i_prev_valid,
    input  logic                i_prev_keep,
    input  rsdk_pkg::t_rec      i_next_rec,
    input  logic                i_next_valid,
    output rsdk_pkg::t_rec      o_rec,
    output logic                o_valid,
    output logic                o_keep
);

    rsdk_pkg::t_rec r_rec, n_rec;
    logic           r_valid, n_valid;
    logic           w_keep;

    // equal scores stay ahead of the newcomer, which keeps arrival order
    assign w_keep = r_valid && (r_rec.score >= i_new.score);

    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        priority if (i_ctrl.pop) begin
            n_rec   = i_next_rec;
            n_valid = i_next_valid;
        end else if (i_ctrl.ins && !w_keep) begin
            if (i_prev_keep) begin
                n_rec   = i_new;
                n_valid = 1'b1;
            end else begin
                n_rec   = i_prev_rec;
                n_valid = i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec   = r_rec;
    assign o_valid = r_valid;
    assign o_keep  = w_keep;

endmodule

[sv/record_sort_descending_key.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_descending_key
// stable insertion sorter, descending score, over a chain of record cells
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  ----------------------------------
//  s_axis    in   tvalid / tready           tdata {score, handle, id}, tlast
//  m_axis    out  tvalid / tready           tdata {score, handle, id}, tlast,
//                                           tuser = overflow
//
//  every cell compares an accepted record with its own record, and the
//  chain opens a gap at the insertion point at the accepting clock edge
//  after a word with tlast the chain drains from its head, one word per
//  cycle while m_axis_tready is high; no input is taken during the drain
//  output stalls simply freeze the chain; the head cell is the output register
//  synchronous active-low reset empties the chain and clears the flags
//
// ----------------------------------------------------------------------------

module record_sort_descending_key (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [rsdk_pkg::TDATA_W-1:0]  i_s_axis_tdata,  // rec_id, name_handle, score
    input  logic                          i_s_axis_tlast,  // last_in
    // master side
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [rsdk_pkg::TDATA_W-1:0]  o_m_axis_tdata,  // out_id, out_handle, out_score
    output logic                          o_m_axis_tlast,  // last_out
    output logic                          o_m_axis_tuser   // overflow
);

    localparam int N = rsdk_pkg::MAX_RECORDS;

    rsdk_pkg::t_state     r_state, n_state;
    logic [rsdk_pkg::CNT_W-1:0] r_count, n_count;
    logic                 r_ovf, n_ovf;

    rsdk_pkg::t_rec       w_new;
    rsdk_pkg::t_cell_ctrl w_ctrl;
    rsdk_pkg::t_rec       w_rec   [N];
    logic                 w_valid [N];
    logic                 w_keep  [N];

    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_full;

    // incoming word unpacked into a record
    assign w_new = i_s_axis_tdata[rsdk_pkg::REC_W-1:0];

    assign w_full    = (r_count == rsdk_pkg::CNT_W'(N));
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // a full chain drops the record and only flags it
    assign w_ctrl.ins = w_in_acc && !w_full;
    assign w_ctrl.pop = w_out_acc;

    // the chain of cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        rsdk_pkg::t_rec w_prev_rec, w_next_rec;
        logic           w_prev_valid, w_prev_keep, w_next_valid;

        if (g == 0) begin : g_head
            // head takes the new record whenever it does not keep its own
            assign w_prev_rec   = w_new;
            assign w_prev_valid = 1'b1;
            assign w_prev_keep  = 1'b1;
        end else begin : g_mid
            assign w_prev_rec   = w_rec[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_keep  = w_keep[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign w_next_rec   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_body
            assign w_next_rec   = w_rec[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        rsdk_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new        (w_new),
            .i_prev_rec   (w_prev_rec),
            .i_prev_valid (w_prev_valid),
            .i_prev_keep  (w_prev_keep),
            .i_next_rec   (w_next_rec),
            .i_next_valid (w_next_valid),
            .o_rec        (w_rec[g]),
            .o_valid      (w_valid[g]),
            .o_keep       (w_keep[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsdk_pkg::ST_FILL: begin
                if (w_in_acc && i_s_axis_tlast) begin
                    n_state = rsdk_pkg::ST_DRAIN;
                end
            end
            rsdk_pkg::ST_DRAIN: begin
                if (w_out_acc && o_m_axis_tlast) begin
                    n_state = rsdk_pkg::ST_FILL;
                end
            end
            default: n_state = rsdk_pkg::ST_FILL;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            rsdk_pkg::ST_FILL:  o_s_axis_tready = 1'b1;
            rsdk_pkg::ST_DRAIN: o_m_axis_tvalid = w_valid[0];
            default: begin
                o_s_axis_tready = 1'b0;
                o_m_axis_tvalid = 1'b0;
            end
        endcase
    end

    // record count and overflow flag
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_ctrl.ins) begin
            n_count = r_count + rsdk_pkg::CNT_W'(1);
        end
        if (w_in_acc && w_full) begin
            n_ovf = 1'b1;
        end
        if (w_out_acc) begin
            n_count = r_count - rsdk_pkg::CNT_W'(1);
            if (o_m_axis_tlast) begin
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsdk_pkg::ST_FILL;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // head of the chain is the output word
    assign o_m_axis_tdata = {{(rsdk_pkg::TDATA_W - rsdk_pkg::REC_W){1'b0}}, w_rec[0]};
    assign o_m_axis_tlast = (r_count == rsdk_pkg::CNT_W'(1));
    assign o_m_axis_tuser = r_ovf;

endmodule

[dv/record_sort_descending_key_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_descending_key_tb
// self-checking bench for the stable descending-score record sorter
// ----------------------------------------------------------------------------
//
//  batches of records are streamed into the slave side; a local model keeps
//  its own ranked store, and on every word with tlast it queues the whole
//  sorted run as expected output words. a monitor on the master side pops
//  the oldest expected word for each accepted word and compares id, handle,
//  score, tlast and the overflow flag. both sides stall in random bursts
//  except in the closing test, which runs with no idling at all.
//
// ----------------------------------------------------------------------------

module record_sort_descending_key_tb;

    // one expected word of a sorted run
    typedef struct {
        rsdk_pkg::t_rec rec;
        logic           last;
        logic           ovf;
    } t_sorted_word;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    logic [rsdk_pkg::TDATA_W-1:0]  i_s_axis_tdata;   // rec_id, name_handle, score
    logic                          i_s_axis_tlast;   // last_in
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    logic [rsdk_pkg::TDATA_W-1:0]  o_m_axis_tdata;   // out_id, out_handle, out_score
    logic                          o_m_axis_tlast;   // last_out
    logic                          o_m_axis_tuser;   // overflow

    // model state: ranked store, fill level, dropped-record flag
    rsdk_pkg::t_rec       ranked_recs [rsdk_pkg::MAX_RECORDS];
    int                   ranked_cnt;
    bit                   batch_dropped;

    // sorted words still owed by the block
    t_sorted_word         sorted_q [$];

    int                   err_cnt;
    bit                   idle_on;
    int                   stall_left;

    record_sort_descending_key dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .o_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_s_axis_tlast   (i_s_axis_tlast),
        .o_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .o_m_axis_tdata   (o_m_axis_tdata),
        .o_m_axis_tlast   (o_m_axis_tlast),
        .o_m_axis_tuser   (o_m_axis_tuser)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // hard stop in case the block hangs
    initial begin
        #500000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------

    // insert behind every stored record of equal or higher score, so ties
    // keep arrival order; a full store drops the record and marks the batch
    task automatic rank_record(input rsdk_pkg::t_rec r, input bit last);
        int pos;
        int k;
        t_sorted_word w;
        if (ranked_cnt >= rsdk_pkg::MAX_RECORDS) begin
            batch_dropped = 1'b1;
        end else begin
            pos = 0;
            while (pos < ranked_cnt && ranked_recs[pos].score >= r.score)
                pos++;
            for (k = ranked_cnt; k > pos; k--)
                ranked_recs[k] = ranked_recs[k-1];
            ranked_recs[pos] = r;
            ranked_cnt++;
        end
        // end of batch: the whole store goes out, then a fresh batch starts
        if (last) begin
            for (k = 0; k < ranked_cnt; k++) begin
                w.rec  = ranked_recs[k];
                w.last = (k == ranked_cnt - 1);
                w.ovf  = batch_dropped;
                sorted_q.push_back(w);
            end
            ranked_cnt    = 0;
            batch_dropped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // slave-side driver
    // ------------------------------------------------------------------------

    // drives one word at a falling edge, holds it until accepted, and hands
    // it to the model; returns right after the accepting rising edge so the
    // next call can keep tvalid high with no drop
    task automatic send_record(input rsdk_pkg::t_rec r, input bit last);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rsdk_pkg::TDATA_W'(r);
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        rank_record(r, last);
    endtask

    // random record; in tie mode scores come from four values only
    function automatic rsdk_pkg::t_rec rand_record(input bit ties);
        rsdk_pkg::t_rec r;
        r.id     = $urandom;
        r.handle = rsdk_pkg::HANDLE_W'($urandom_range(0, 16'hFFFF));
        r.score  = ties ? rsdk_pkg::SCORE_W'($urandom_range(0, 3) * 341)
                        : rsdk_pkg::SCORE_W'($urandom_range(0, 2047));
        return r;
    endfunction

    task automatic send_batch(input int n, input bit ties);
        for (int i = 0; i < n; i++)
            send_record(rand_record(ties), i == n - 1);
    endtask

    // ------------------------------------------------------------------------
    // master-side stall generator and monitor
    // ------------------------------------------------------------------------

    initial begin
        i_m_axis_tready = 1'b0;
        stall_left      = 0;
        forever begin
            @(negedge i_clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // every accepted output word is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_sorted_word   want;
        rsdk_pkg::t_rec got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[rsdk_pkg::REC_W-1:0];
            if (sorted_q.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, actual tdata %h", $time,
                         o_m_axis_tdata);
                err_cnt++;
            end else begin
                want = sorted_q.pop_front();
                check_field("id",       want.rec.id,     got.id);
                check_field("handle",   32'(want.rec.handle), 32'(got.handle));
                check_field("score",    32'(want.rec.score),  32'(got.score));
                check_field("tlast",    32'(want.last),       32'(o_m_axis_tlast));
                check_field("overflow", 32'(want.ovf),        32'(o_m_axis_tuser));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // one-record batches at both extremes of every field
    task automatic test_single_record();
        send_record('{score: '0, handle: '0, id: '0}, 1'b1);
        send_record('{score: '1, handle: '1, id: '1}, 1'b1);
    endtask

    // score extremes and the neighbours of 1024 in one batch
    task automatic test_score_extremes();
        send_record('{score: 11'd1024, handle: 16'h0000, id: 32'hFFFF_FFFF}, 1'b0);
        send_record('{score: 11'd0,    handle: 16'hFFFF, id: 32'h0000_0000}, 1'b0);
        send_record('{score: 11'd2047, handle: 16'hA5A5, id: 32'h5A5A_5A5A}, 1'b0);
        send_record('{score: 11'd1,    handle: 16'h5A5A, id: 32'hA5A5_A5A5}, 1'b0);
        send_record('{score: 11'd1025, handle: 16'h0001, id: 32'h8000_0000}, 1'b0);
        send_record('{score: 11'd1023, handle: 16'h8000, id: 32'h0000_0001}, 1'b1);
    endtask

    // equal scores must come out in arrival order
    task automatic test_equal_scores();
        for (int i = 0; i < 6; i++)
            send_record('{score: (i % 2) ? 11'd512 : 11'd768, handle: 16'(i),
                          id: 32'(100 + i)}, i == 5);
    endtask

    // ascending scores: every new record lands at the head
    task automatic test_ascending();
        for (int i = 0; i < 5; i++)
            send_record('{score: 11'(i * 200), handle: 16'(i), id: 32'(200 + i)}, i == 4);
    endtask

    // store filled exactly, then overfilled so the last word itself is dropped
    task automatic test_store_full();
        send_batch(rsdk_pkg::MAX_RECORDS, 1'b0);
        send_batch(rsdk_pkg::MAX_RECORDS + 3, 1'b1);
    endtask

    // short random batches, about half of them rich in ties
    task automatic test_random_batches();
        int sent;
        int n;
        sent = 0;
        while (sent < 80) begin
            n = $urandom_range(1, 12);
            send_batch(n, $urandom_range(0, 1));
            sent += n;
        end
    endtask

    // closing stretch with both sides running flat out
    task automatic test_no_idle();
        int sent;
        int n;
        idle_on = 1'b0;
        sent    = 0;
        while (sent < 30) begin
            n = $urandom_range(1, 10);
            send_batch(n, $urandom_range(0, 1));
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        int waited;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        idle_on         = 1'b1;
        err_cnt         = 0;
        ranked_cnt      = 0;
        batch_dropped   = 1'b0;

        // hold the synchronous reset, then release it
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_record();
        test_score_extremes();
        test_equal_scores();
        test_ascending();
        test_store_full();
        test_random_batches();
        test_no_idle();

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;

        // drain whatever is still owed, bounded
        waited = 0;
        while (sorted_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (sorted_q.size() != 0) begin
            $display("%0t ns: missing words, expected %0d more, actual 0", $time,
                     sorted_q.size());
            err_cnt++;
        end
        // settle so stray trailing words are still caught
        repeat (20) @(posedge i_clk);

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
